### rtl/core/blzd_pkg.sv
// ----------------------------------------------------------------------------
// blzd_pkg
// Types and constants shared by the backward lz bitstream decoder files.
// ----------------------------------------------------------------------------
package blzd_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned NUMBER_BITS = 24;
   localparam int unsigned STAGE_BITS  = 24;
   localparam int unsigned RUN_BITS    = 9;

   localparam logic [WORD_BITS-1:0] RESERVOIR_MARKER = 32'h8000_0000;

   localparam logic [3:0] SEL_FIELD_BITS  = 4'd2;
   localparam logic [3:0] LIT3_FIELD_BITS = 4'd3;
   localparam logic [3:0] LIT7_FIELD_BITS = 4'd7;
   localparam logic [3:0] BYTE_FIELD_BITS = 4'd8;

   localparam logic [RUN_BITS-1:0] PAIR_COPY_RUN  = 9'd2;
   localparam logic [RUN_BITS-1:0] SHORT_COPY_ADD = 9'd3;
   localparam logic [RUN_BITS-1:0] LONG_COPY_ADD  = 9'd5;
   localparam logic [RUN_BITS-1:0] SHORT_LIT_ADD  = 9'd1;
   localparam logic [RUN_BITS-1:0] LONG_LIT_ADD   = 9'd9;

   localparam logic [7:0] SEL_LONG_LITERAL = 8'd3;
   localparam logic [7:0] SEL_SHORT_LIMIT  = 8'd2;

   typedef enum logic {
      OP_WORD = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   typedef enum logic [8:0] {
      PH_TOKEN   = 9'b000000001,
      PH_KIND    = 9'b000000010,
      PH_SEL2    = 9'b000000100,
      PH_LIT3    = 9'b000001000,
      PH_LIT7    = 9'b000010000,
      PH_LEN8    = 9'b000100000,
      PH_DIST    = 9'b001000000,
      PH_LITBYTE = 9'b010000000,
      PH_COPY    = 9'b100000000
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE = 3'b001,
      CTL_STEP = 3'b010,
      CTL_READ = 3'b100
   } ctl_type;

   typedef struct packed {
      logic                 op;
      logic [WORD_BITS-1:0] packed_word;
   } req_type;

   typedef struct packed {
      logic                   byte_valid;
      logic [7:0]             data_byte;
      logic [NUMBER_BITS-1:0] byte_number;
      logic                   need_word;
      logic                   finished;
   } rsp_type;

endpackage

### rtl/core/blzd_ram.sv
// ----------------------------------------------------------------------------
// blzd_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module blzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/backward_lz_bitstream_decoder_top.sv
// ----------------------------------------------------------------------------
// backward_lz_bitstream_decoder_top
// Pull driven lz decoder over a backward packed bitstream with 256 byte history.
// ----------------------------------------------------------------------------
// usage
//   req channel: op 0 supplies a packed word (taken while idle, no result),
//   op 1 pulls the next byte and yields exactly one rsp item.
//   rsp channel: registered output; byte_valid marks a decoded byte, need_word
//   asks for another word, finished marks the end of the stream.
//   csr port: write stage_length at any time the block is idle.
// operation
//   after a pull is accepted the block takes bits from the reservoir one at
//   a time and makes each field decision as a step of its own; a copy byte
//   reads the history ram first and loads the result register after that.
//   one item is worked on at a time; req_stall is high while a pull runs.
// reset
//   synchronous; clears the reservoir, token state and counts. history
//   entries not yet written give zero to a copy, so no clear pass.
// stall
//   while rsp_stall holds a result, a pull that finishes waits for the
//   output register; word items are still taken.
// ----------------------------------------------------------------------------
module backward_lz_bitstream_decoder_top #(
   parameter int COUNT_BITS    = 24,
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  blzd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output blzd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [blzd_pkg::STAGE_BITS-1:0]     csr_wr_data
);

   localparam int AW   = $clog2(HISTORY_DEPTH);
   localparam int CMPW = (COUNT_BITS > blzd_pkg::STAGE_BITS) ? COUNT_BITS
                                                              : blzd_pkg::STAGE_BITS;
   localparam int NUMW = (COUNT_BITS > blzd_pkg::NUMBER_BITS) ? COUNT_BITS
                                                               : blzd_pkg::NUMBER_BITS;

   blzd_pkg::ctl_type   ctl_ff, ctl_in;
   blzd_pkg::phase_type phase_ff, phase_in;

   logic [blzd_pkg::STAGE_BITS-1:0] stage_ff, stage_in;
   logic [blzd_pkg::WORD_BITS-1:0]  reservoir_ff, reservoir_in;
   logic                            first_seen_ff, first_seen_in;
   logic                            staged_valid_ff, staged_valid_in;
   logic                            staged_bit_ff, staged_bit_in;
   logic [7:0]                      acc_ff, acc_in;
   logic [3:0]                      bits_left_ff, bits_left_in;
   logic [blzd_pkg::RUN_BITS-1:0]   run_ff, run_in;
   logic [7:0]                      dist_ff, dist_in;
   logic [COUNT_BITS-1:0]           count_ff, count_in;
   logic                            wrapped_ff, wrapped_in;
   logic                            done_ff, done_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   blzd_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                          bit_avail;
   logic                          bit_val;
   logic                          take;
   logic                          emit;
   logic [7:0]                    emit_val;
   logic                          need;
   logic                          slot_free;
   logic                          is_field;
   logic                          copy_zero;
   logic [COUNT_BITS-1:0]         count_inc;
   logic                          wrap_next;
   logic [blzd_pkg::RUN_BITS-1:0] run_dec;
   logic                          done_next;
   logic [NUMW-1:0]               count_wide;
   logic [blzd_pkg::NUMBER_BITS-1:0] count_num;

   logic          ram_we;
   logic          ram_re;
   logic [AW-1:0] ram_wr_addr;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   blzd_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (emit_val),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign bit_avail = staged_valid_ff || (first_seen_ff && (|reservoir_ff[31:1]));
   assign bit_val   = staged_valid_ff ? staged_bit_ff : reservoir_ff[0];
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_field  = (phase_ff inside {blzd_pkg::PH_SEL2, blzd_pkg::PH_LIT3,
                                        blzd_pkg::PH_LIT7, blzd_pkg::PH_LEN8,
                                        blzd_pkg::PH_DIST, blzd_pkg::PH_LITBYTE});
   assign copy_zero = (dist_ff == 8'd0) ||
                      (!wrapped_ff && (COUNT_BITS'(dist_ff) > count_ff));
   assign count_inc = count_ff + COUNT_BITS'(1);
   assign wrap_next = wrapped_ff || (count_inc == '0);
   assign run_dec   = (run_ff != '0) ? (run_ff - blzd_pkg::RUN_BITS'(1)) : run_ff;
   assign done_next = wrap_next || (CMPW'(count_inc) >= CMPW'(stage_ff));
   assign count_wide = NUMW'(count_ff);
   assign count_num  = count_wide[blzd_pkg::NUMBER_BITS-1:0];
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_rd_addr = count_ff[AW-1:0] - AW'(dist_ff);

   always_comb begin
      ctl_in          = ctl_ff;
      phase_in        = phase_ff;
      stage_in        = stage_ff;
      reservoir_in    = reservoir_ff;
      first_seen_in   = first_seen_ff;
      staged_valid_in = staged_valid_ff;
      staged_bit_in   = staged_bit_ff;
      acc_in          = acc_ff;
      bits_left_in    = bits_left_ff;
      run_in          = run_ff;
      dist_in         = dist_ff;
      count_in        = count_ff;
      wrapped_in      = wrapped_ff;
      done_in         = done_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      take            = 1'b0;
      emit            = 1'b0;
      emit_val        = acc_ff;
      need            = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;

      if (csr_wr_en) begin
         stage_in = csr_wr_data;
      end

      case (ctl_ff)
         blzd_pkg::CTL_IDLE: begin
            if (req_valid) begin
               if (req_data.op == blzd_pkg::OP_PULL) begin
                  ctl_in = blzd_pkg::CTL_STEP;
               end else if (!first_seen_ff) begin
                  reservoir_in  = req_data.packed_word;
                  first_seen_in = 1'b1;
               end else if (!staged_valid_ff && !(|reservoir_ff[31:1])) begin
                  staged_bit_in   = req_data.packed_word[0];
                  staged_valid_in = 1'b1;
                  reservoir_in    = (req_data.packed_word >> 1) | blzd_pkg::RESERVOIR_MARKER;
               end
            end
         end
         blzd_pkg::CTL_STEP: begin
            if (done_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{byte_valid: 1'b0, data_byte: 8'd0,
                                   byte_number: count_num, need_word: 1'b0,
                                   finished: 1'b1};
                  ctl_in       = blzd_pkg::CTL_IDLE;
               end
            end else if (is_field && (bits_left_ff != 4'd0)) begin
               if (bit_avail) begin
                  take         = 1'b1;
                  acc_in       = {acc_ff[6:0], bit_val};
                  bits_left_in = bits_left_ff - 4'd1;
               end else begin
                  need = 1'b1;
               end
            end else begin
               case (phase_ff)
                  blzd_pkg::PH_TOKEN: begin
                     if (bit_avail) begin
                        take = 1'b1;
                        if (bit_val) begin
                           phase_in     = blzd_pkg::PH_SEL2;
                           acc_in       = 8'd0;
                           bits_left_in = blzd_pkg::SEL_FIELD_BITS;
                        end else begin
                           phase_in = blzd_pkg::PH_KIND;
                        end
                     end else begin
                        need = 1'b1;
                     end
                  end
                  blzd_pkg::PH_KIND: begin
                     if (bit_avail) begin
                        take   = 1'b1;
                        acc_in = 8'd0;
                        if (bit_val) begin
                           run_in       = blzd_pkg::PAIR_COPY_RUN;
                           phase_in     = blzd_pkg::PH_DIST;
                           bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
                        end else begin
                           phase_in     = blzd_pkg::PH_LIT3;
                           bits_left_in = blzd_pkg::LIT3_FIELD_BITS;
                        end
                     end else begin
                        need = 1'b1;
                     end
                  end
                  blzd_pkg::PH_SEL2: begin
                     acc_in = 8'd0;
                     if (acc_ff < blzd_pkg::SEL_SHORT_LIMIT) begin
                        run_in       = blzd_pkg::RUN_BITS'(acc_ff) + blzd_pkg::SHORT_COPY_ADD;
                        phase_in     = blzd_pkg::PH_DIST;
                        bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
                     end else if (acc_ff == blzd_pkg::SEL_LONG_LITERAL) begin
                        phase_in     = blzd_pkg::PH_LIT7;
                        bits_left_in = blzd_pkg::LIT7_FIELD_BITS;
                     end else begin
                        phase_in     = blzd_pkg::PH_LEN8;
                        bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
                     end
                  end
                  blzd_pkg::PH_LIT3: begin
                     run_in       = blzd_pkg::RUN_BITS'(acc_ff) + blzd_pkg::SHORT_LIT_ADD;
                     acc_in       = 8'd0;
                     phase_in     = blzd_pkg::PH_LITBYTE;
                     bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
                  end
                  blzd_pkg::PH_LIT7: begin
                     run_in       = blzd_pkg::RUN_BITS'(acc_ff) + blzd_pkg::LONG_LIT_ADD;
                     acc_in       = 8'd0;
                     phase_in     = blzd_pkg::PH_LITBYTE;
                     bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
                  end
                  blzd_pkg::PH_LEN8: begin
                     run_in       = blzd_pkg::RUN_BITS'(acc_ff) + blzd_pkg::LONG_COPY_ADD;
                     acc_in       = 8'd0;
                     phase_in     = blzd_pkg::PH_DIST;
                     bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
                  end
                  blzd_pkg::PH_DIST: begin
                     dist_in  = acc_ff;
                     phase_in = blzd_pkg::PH_COPY;
                  end
                  blzd_pkg::PH_LITBYTE: begin
                     if (slot_free) begin
                        emit     = 1'b1;
                        emit_val = acc_ff;
                     end
                  end
                  blzd_pkg::PH_COPY: begin
                     ram_re = 1'b1;
                     ctl_in = blzd_pkg::CTL_READ;
                  end
                  default: begin
                     phase_in = blzd_pkg::PH_TOKEN;
                  end
               endcase
            end
         end
         blzd_pkg::CTL_READ: begin
            if (slot_free) begin
               emit     = 1'b1;
               emit_val = copy_zero ? 8'd0 : ram_rd_data;
            end
         end
         default: begin
            ctl_in = blzd_pkg::CTL_IDLE;
         end
      endcase

      if (take) begin
         if (staged_valid_ff) begin
            staged_valid_in = 1'b0;
         end else begin
            reservoir_in = reservoir_ff >> 1;
         end
      end

      if (need && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{byte_valid: 1'b0, data_byte: 8'd0,
                          byte_number: count_num, need_word: 1'b1,
                          finished: 1'b0};
         ctl_in       = blzd_pkg::CTL_IDLE;
      end

      if (emit) begin
         ram_we     = 1'b1;
         count_in   = count_inc;
         wrapped_in = wrap_next;
         run_in     = run_dec;
         if (run_dec == '0) begin
            done_in  = done_next;
            phase_in = blzd_pkg::PH_TOKEN;
         end else if (phase_ff == blzd_pkg::PH_LITBYTE) begin
            acc_in       = 8'd0;
            bits_left_in = blzd_pkg::BYTE_FIELD_BITS;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{byte_valid: 1'b1, data_byte: emit_val,
                          byte_number: count_num, need_word: 1'b0,
                          finished: (run_dec == '0) ? done_next : done_ff};
         ctl_in       = blzd_pkg::CTL_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff          <= blzd_pkg::CTL_IDLE;
         phase_ff        <= blzd_pkg::PH_TOKEN;
         stage_ff        <= blzd_pkg::STAGE_BITS'(1);
         reservoir_ff    <= '0;
         first_seen_ff   <= 1'b0;
         staged_valid_ff <= 1'b0;
         staged_bit_ff   <= 1'b0;
         acc_ff          <= 8'd0;
         bits_left_ff    <= 4'd0;
         run_ff          <= '0;
         dist_ff         <= 8'd0;
         count_ff        <= '0;
         wrapped_ff      <= 1'b0;
         done_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         ctl_ff          <= ctl_in;
         phase_ff        <= phase_in;
         stage_ff        <= stage_in;
         reservoir_ff    <= reservoir_in;
         first_seen_ff   <= first_seen_in;
         staged_valid_ff <= staged_valid_in;
         staged_bit_ff   <= staged_bit_in;
         acc_ff          <= acc_in;
         bits_left_ff    <= bits_left_in;
         run_ff          <= run_in;
         dist_ff         <= dist_in;
         count_ff        <= count_in;
         wrapped_ff      <= wrapped_in;
         done_ff         <= done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (ctl_ff != blzd_pkg::CTL_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/blzd_checker.sv
// ----------------------------------------------------------------------------
// blzd_checker
// Port level checks on the backward lz bitstream decoder, bound to the top.
// ----------------------------------------------------------------------------
module blzd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input blzd_pkg::req_type               req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input blzd_pkg::rsp_type               rsp_data,
   input logic                            csr_wr_en,
   input logic [blzd_pkg::STAGE_BITS-1:0] csr_wr_data
);

   logic csr_seen;

   assign csr_seen = csr_wr_en && (csr_wr_data == csr_wr_data);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // a word item never creates a result
   a_word_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.op == blzd_pkg::OP_WORD) && !rsp_valid)
      |=> !rsp_valid)
      else $error("word item produced a result");

   // a config write alone never creates a result
   a_csr_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (csr_seen && !rsp_valid && !(req_valid && !req_stall) && !req_stall)
      |=> !rsp_valid)
      else $error("config write produced a result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind backward_lz_bitstream_decoder_top blzd_checker u_blzd_checker (.*);

### bench/tb_backward_lz_bitstream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backward_lz_bitstream_decoder_top
// Self-checking bench for the pull driven backward lz decoder. A directed
// table walks the first word, reloads, unneeded words, pulls with an empty
// reservoir and every copy form and the short literal form with odd
// distances. Then random packed words and pulls follow. Each item is run
// through a bench-side decoder model and the byte results are compared
// field by field, under random idling, a long receiver hold-off and several
// stage_length values that end with the stream being finished.
// ----------------------------------------------------------------------------
module tb_backward_lz_bitstream_decoder_top;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 30;
   localparam int DIRECTED_ROWS  = 24;

   typedef struct packed {
      blzd_pkg::op_type                       op;
      logic [blzd_pkg::WORD_BITS-1:0]         word;
      logic                                   typed;
      blzd_pkg::rsp_type                      want;
   } step_row_type;

   localparam blzd_pkg::rsp_type NO_BITS_YET = '{byte_valid: 1'b0, data_byte: 8'h00,
                                                 byte_number: '0, need_word: 1'b1,
                                                 finished: 1'b0};

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   blzd_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   blzd_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en;
   logic [blzd_pkg::STAGE_BITS-1:0] csr_wr_data;

   // decoder model state
   logic [blzd_pkg::STAGE_BITS-1:0]  want_bytes;
   logic [blzd_pkg::WORD_BITS-1:0]   bit_pool;
   logic                             pool_primed;
   logic                             spare_ok;
   logic                             spare_bit;
   blzd_pkg::phase_type              phase;
   logic [7:0]                       field_acc;
   logic [3:0]                       field_left;
   logic [blzd_pkg::RUN_BITS-1:0]    run_left;
   logic [7:0]                       copy_dist;
   logic [blzd_pkg::NUMBER_BITS-1:0] byte_count;
   logic                             count_wrapped;
   logic [7:0]                       history [256];
   logic                             stream_done;

   blzd_pkg::rsp_type expected_bytes [$];
   int                mismatches;
   int                items_taken;
   int                quiet_cycles;
   logic              row_typed;
   blzd_pkg::rsp_type row_want;
   logic              sender_idles;
   logic              receiver_idles;
   logic              rsp_hold_req;

   backward_lz_bitstream_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic pool_empty();
      return !spare_ok && (!pool_primed || bit_pool < 2);
   endfunction

   function automatic logic draw_bit(output logic b);
      b = 1'b0;
      if (spare_ok) begin
         b        = spare_bit;
         spare_ok = 1'b0;
         return 1'b1;
      end
      if (!pool_primed || bit_pool < 2) return 1'b0;
      b        = bit_pool[0];
      bit_pool = bit_pool >> 1;
      return 1'b1;
   endfunction

   // returns 1 when the word is loaded, 0 when the reservoir still had bits
   function automatic logic take_word(input logic [blzd_pkg::WORD_BITS-1:0] w);
      if (!pool_primed) begin
         bit_pool    = w;
         pool_primed = 1'b1;
         return 1'b1;
      end
      if (pool_empty()) begin
         spare_bit = w[0];
         spare_ok  = 1'b1;
         bit_pool  = (w >> 1) | blzd_pkg::RESERVOIR_MARKER;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void open_field(input blzd_pkg::phase_type p, input logic [3:0] n);
      phase      = p;
      field_acc  = '0;
      field_left = n;
   endfunction

   function automatic blzd_pkg::rsp_type decode_next_byte();
      blzd_pkg::rsp_type   r;
      blzd_pkg::phase_type ph;
      logic                b;
      logic                settled;
      logic [7:0]          v;
      logic [7:0]          slot;
      r             = '0;
      r.byte_number = byte_count;
      r.finished    = stream_done;
      settled       = stream_done;
      while (!settled) begin
         ph = phase;
         if (field_left != 0 &&
             ph inside {blzd_pkg::PH_SEL2, blzd_pkg::PH_LIT3, blzd_pkg::PH_LIT7,
                        blzd_pkg::PH_LEN8, blzd_pkg::PH_DIST, blzd_pkg::PH_LITBYTE}) begin
            if (!draw_bit(b)) begin
               r.need_word = 1'b1;
               settled     = 1'b1;
            end else begin
               field_acc  = {field_acc[6:0], b};
               field_left = field_left - 1'b1;
            end
         end else begin
            case (ph)
               blzd_pkg::PH_TOKEN, blzd_pkg::PH_KIND: begin
                  if (!draw_bit(b)) begin
                     r.need_word = 1'b1;
                     settled     = 1'b1;
                  end else if (ph == blzd_pkg::PH_TOKEN) begin
                     if (b) begin
                        open_field(blzd_pkg::PH_SEL2, blzd_pkg::SEL_FIELD_BITS);
                     end else begin
                        phase = blzd_pkg::PH_KIND;
                     end
                  end else if (b) begin
                     run_left = blzd_pkg::PAIR_COPY_RUN;
                     open_field(blzd_pkg::PH_DIST, blzd_pkg::BYTE_FIELD_BITS);
                  end else begin
                     open_field(blzd_pkg::PH_LIT3, blzd_pkg::LIT3_FIELD_BITS);
                  end
               end
               blzd_pkg::PH_SEL2: begin
                  if (field_acc < blzd_pkg::SEL_SHORT_LIMIT) begin
                     run_left = field_acc + blzd_pkg::SHORT_COPY_ADD;
                     open_field(blzd_pkg::PH_DIST, blzd_pkg::BYTE_FIELD_BITS);
                  end else if (field_acc == blzd_pkg::SEL_LONG_LITERAL) begin
                     open_field(blzd_pkg::PH_LIT7, blzd_pkg::LIT7_FIELD_BITS);
                  end else begin
                     open_field(blzd_pkg::PH_LEN8, blzd_pkg::BYTE_FIELD_BITS);
                  end
               end
               blzd_pkg::PH_LIT3: begin
                  run_left = field_acc + blzd_pkg::SHORT_LIT_ADD;
                  open_field(blzd_pkg::PH_LITBYTE, blzd_pkg::BYTE_FIELD_BITS);
               end
               blzd_pkg::PH_LIT7: begin
                  run_left = field_acc + blzd_pkg::LONG_LIT_ADD;
                  open_field(blzd_pkg::PH_LITBYTE, blzd_pkg::BYTE_FIELD_BITS);
               end
               blzd_pkg::PH_LEN8: begin
                  run_left = field_acc + blzd_pkg::LONG_COPY_ADD;
                  open_field(blzd_pkg::PH_DIST, blzd_pkg::BYTE_FIELD_BITS);
               end
               blzd_pkg::PH_DIST: begin
                  copy_dist = field_acc;
                  phase     = blzd_pkg::PH_COPY;
               end
               blzd_pkg::PH_LITBYTE, blzd_pkg::PH_COPY: begin
                  slot = byte_count[7:0] - copy_dist;
                  if (ph == blzd_pkg::PH_LITBYTE) begin
                     v = field_acc;
                  end else if (copy_dist == 0 ||
                               (!count_wrapped && copy_dist > byte_count)) begin
                     v = 8'h00;
                  end else begin
                     v = history[slot];
                  end
                  history[byte_count[7:0]] = v;
                  r.byte_number = byte_count;
                  byte_count    = byte_count + 1'b1;
                  if (byte_count == '0) count_wrapped = 1'b1;
                  if (run_left != 0) run_left = run_left - 1'b1;
                  if (run_left == 0) begin
                     if (count_wrapped || byte_count >= want_bytes) stream_done = 1'b1;
                     phase = blzd_pkg::PH_TOKEN;
                  end else if (ph == blzd_pkg::PH_LITBYTE) begin
                     open_field(blzd_pkg::PH_LITBYTE, blzd_pkg::BYTE_FIELD_BITS);
                  end
                  r.byte_valid = 1'b1;
                  r.data_byte  = v;
                  r.finished   = stream_done;
                  settled      = 1'b1;
               end
               default: begin
                  phase = blzd_pkg::PH_TOKEN;
               end
            endcase
         end
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         if (mismatches < 100) $display("%0t: %s is %0h, expected %0h", $time, what, got, want);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      blzd_pkg::rsp_type got_pull;
      blzd_pkg::rsp_type want;
      logic              moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_wr_en) want_bytes = csr_wr_data;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (req_data.op == blzd_pkg::OP_PULL) begin
               got_pull = decode_next_byte();
               expected_bytes.push_back(row_typed ? row_want : got_pull);
               items_taken++;
            end else if (take_word(req_data.packed_word)) begin
               items_taken++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_bytes.size() == 0) begin
               check_field("item with nothing expected", 1, 0);
            end else begin
               want = expected_bytes.pop_front();
               check_field("byte_valid", rsp_data.byte_valid, want.byte_valid);
               check_field("data_byte", rsp_data.data_byte, want.data_byte);
               check_field("byte_number", rsp_data.byte_number, want.byte_number);
               check_field("need_word", rsp_data.need_word, want.need_word);
               check_field("finished", rsp_data.finished, want.finished);
            end
         end
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // receiver side: random stall bursts, or one long hold when asked
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            stall_left   = HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(input blzd_pkg::req_type item, input logic typed,
                       input blzd_pkg::rsp_type want);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      row_typed = typed;
      row_want  = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // mostly words when the reservoir is dry, mostly pulls otherwise
   function automatic blzd_pkg::req_type next_item();
      blzd_pkg::req_type item;
      int                word_odds;
      item.packed_word = $urandom;
      if (stream_done) begin
         word_odds = 25;
      end else if (pool_empty()) begin
         word_odds = 88;
      end else begin
         word_odds = 6;
      end
      item.op = ($urandom_range(0, 99) < word_odds) ? blzd_pkg::OP_WORD : blzd_pkg::OP_PULL;
      return item;
   endfunction

   task automatic run_random(input int count);
      int goal;
      goal = items_taken + count;
      while (items_taken < goal) send(next_item(), 1'b0, '0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_stage(input logic [blzd_pkg::STAGE_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      step_row_type      directed_steps [DIRECTED_ROWS];
      blzd_pkg::req_type item;
      // first word 1 carries no bits; the three crafted words hold a short
      // literal pair, a copy at distance one, a copy at distance zero, a copy
      // reaching before the first byte and a long copy at distance seven
      directed_steps = '{
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b1, NO_BITS_YET},
         '{blzd_pkg::OP_WORD, 32'h0000_0001, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b1, NO_BITS_YET},
         '{blzd_pkg::OP_WORD, 32'h4047_94B0, 1'b0, '0},
         '{blzd_pkg::OP_WORD, 32'hFFFF_FFFF, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_WORD, 32'h003F_F201, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_WORD, 32'h0000_0070, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_PULL, 32'h0000_0000, 1'b0, '0},
         '{blzd_pkg::OP_WORD, 32'h0000_0000, 1'b0, '0}
      };
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      row_typed      = 1'b0;
      row_want       = '0;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      rsp_hold_req   = 1'b0;
      mismatches     = 0;
      items_taken    = 0;
      quiet_cycles   = 0;
      want_bytes     = 24'd1;
      bit_pool       = '0;
      pool_primed    = 1'b0;
      spare_ok       = 1'b0;
      spare_bit      = 1'b0;
      phase          = blzd_pkg::PH_TOKEN;
      field_acc      = '0;
      field_left     = '0;
      run_left       = '0;
      copy_dist      = '0;
      byte_count     = '0;
      count_wrapped  = 1'b0;
      stream_done    = 1'b0;
      foreach (history[i]) history[i] = 8'h00;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      write_stage('1);
      foreach (directed_steps[i]) begin
         item.op          = directed_steps[i].op;
         item.packed_word = directed_steps[i].word;
         send(item, directed_steps[i].typed, directed_steps[i].want);
      end

      run_random(700);
      settle();
      write_stage(24'($urandom_range(1_000_000, 16_776_000)));

      // long hold-off on the result side while items keep coming
      rsp_hold_req = 1'b1;
      run_random(550);
      settle();
      write_stage(24'd16_776_000);

      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      run_random(650);
      settle();

      // zero length ends the stream at the next token end
      write_stage('0);
      while (!stream_done) send(next_item(), 1'b0, '0);
      run_random(20);
      settle();

      check_field("items still expected", expected_bytes.size(), 0);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
